@@ src/rpi_pkg.sv @@
// Shared constants, types and helper functions of the ray/parallelogram intersection block.
`default_nettype none
package rpi_pkg;

  localparam int TOL_W     = 10;
  localparam int CFG_IDX_W = 3;
  localparam int QUOT_W    = 32;
  localparam int QB        = QUOT_W - 1;
  localparam int DIV_LAT   = QUOT_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CORNER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_U = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_V = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 3'd4;

  localparam logic [TOL_W-1:0] TOL_RESET = 10'd1;
  localparam logic [QB-1:0]    SAT_MAG   = {QB{1'b1}};

  // Lane numbers of the three divisions.
  localparam int DIV_S = 0;
  localparam int DIV_T = 1;
  localparam int DIV_D = 2;

  typedef struct packed {
    logic valid;
    logic miss;
  } rpi_ctl_t;

  // Width of the cross product components after the fraction shift.
  function automatic int cross_w(input int w, input int f);
    return 2 * w + 1 - f;
  endfunction

  // Common width of all dot product sums and their magnitudes.
  function automatic int mag_w(input int w, input int f);
    int a;
    int b;
    a = cross_w(w, f) + w + 3;
    b = 2 * w + 3;
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

@@ src/rpi_ray_if.sv @@
// Request channel that carries one ray.
`default_nettype none
interface rpi_ray_if #(
  parameter int COORD_WIDTH = 20
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] origin_x;
  logic signed [COORD_WIDTH-1:0] origin_y;
  logic signed [COORD_WIDTH-1:0] origin_z;
  logic signed [COORD_WIDTH-1:0] dir_x;
  logic signed [COORD_WIDTH-1:0] dir_y;
  logic signed [COORD_WIDTH-1:0] dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface
`default_nettype wire

@@ src/rpi_res_if.sv @@
// Result channel that carries hit flag and plane distance.
`default_nettype none
interface rpi_res_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] distance;

  modport source (output valid, hit, distance, input ready);
  modport sink   (input valid, hit, distance, output ready);
endinterface
`default_nettype wire

@@ src/rpi_geom.sv @@
// Five stage pipeline for cross products, dot products and division operands.
`default_nettype none
module rpi_geom #(
  parameter int W  = 20,
  parameter int F  = 10,
  parameter int MW = rpi_pkg::mag_w(20, 10)
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       en_i,
  input  wire                       valid_i,
  input  wire  [2:0][W-1:0]         org_i,
  input  wire  [2:0][W-1:0]         dir_i,
  input  wire  [3*W-1:0]            corner_i,
  input  wire  [3*W-1:0]            normal_i,
  input  wire  [3*W-1:0]            edge_u_i,
  input  wire  [3*W-1:0]            edge_v_i,
  input  wire  [rpi_pkg::TOL_W-1:0] tol_i,
  output rpi_pkg::rpi_ctl_t         ctl_o,
  output logic [2:0][MW-1:0]        num_o,
  output logic [2:0][MW-1:0]        den_o,
  output logic [2:0]                neg_o
);

  localparam int CW = rpi_pkg::cross_w(W, F);
  localparam int TA = 2 * W + 2;
  localparam int TB = rpi_pkg::TOL_W + F + 1;
  localparam int TW = ((TA > TB) ? TA : TB) + 1;
  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  logic signed [W-1:0] c [3];
  logic signed [W-1:0] n [3];
  logic signed [W-1:0] u [3];
  logic signed [W-1:0] v [3];
  logic signed [W-1:0] o [3];
  logic signed [W-1:0] d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c[i] = $signed(corner_i[i*W +: W]);
      n[i] = $signed(normal_i[i*W +: W]);
      u[i] = $signed(edge_u_i[i*W +: W]);
      v[i] = $signed(edge_v_i[i*W +: W]);
      o[i] = $signed(org_i[i]);
      d[i] = $signed(dir_i[i]);
    end
  end

  // Stage A: partial products of both cross products and of N.D, difference C-O.
  logic                  va_q;
  logic signed [2*W-1:0] p1a_q [3];
  logic signed [2*W-1:0] p1b_q [3];
  logic signed [2*W-1:0] p2a_q [3];
  logic signed [2*W-1:0] p2b_q [3];
  logic signed [2*W-1:0] nd_q  [3];
  logic signed [W:0]     vva_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        p1a_q[i] <= v[NXT[i]] * d[PRV[i]];
        p1b_q[i] <= v[PRV[i]] * d[NXT[i]];
        p2a_q[i] <= u[NXT[i]] * d[PRV[i]];
        p2b_q[i] <= u[PRV[i]] * d[NXT[i]];
        nd_q[i]  <= n[i] * d[i];
        vva_q[i] <= c[i] - o[i];
      end
    end
  end

  // Stage B: floored cross products, N.D with the front test, N*VV products.
  logic signed [2*W:0]   dif1 [3];
  logic signed [2*W:0]   dif2 [3];
  logic signed [2*W+1:0] nds;
  logic signed [TW-1:0]  tol_sh;
  logic signed [TW-1:0]  frt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif1[i] = p1a_q[i] - p1b_q[i];
      dif2[i] = p2a_q[i] - p2b_q[i];
    end
    nds    = nd_q[0] + nd_q[1] + nd_q[2];
    tol_sh = $signed(TW'({tol_i, {F{1'b0}}}));
    frt    = nds + tol_sh;
  end

  logic                  vb_q;
  logic signed [CW-1:0]  k1_q  [3];
  logic signed [CW-1:0]  k2_q  [3];
  logic signed [2*W:0]   nvv_q [3];
  logic signed [W:0]     vvb_q [3];
  logic signed [2*W+1:0] ndb_q;
  logic                  frontb_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        k1_q[i]  <= dif1[i][2*W:F];
        k2_q[i]  <= dif2[i][2*W:F];
        nvv_q[i] <= n[i] * vva_q[i];
        vvb_q[i] <= vva_q[i];
      end
      ndb_q    <= nds;
      frontb_q <= frt[TW-1];
    end
  end

  // Stage C: products for the dot products of the cross products with U, V and C-O, sum of N.VV.
  logic                  vc_q;
  logic signed [CW+W-1:0] mu1_q [3];
  logic signed [CW+W-1:0] mu2_q [3];
  logic signed [CW+W:0]   mk1_q [3];
  logic signed [CW+W:0]   mk2_q [3];
  logic signed [2*W+2:0]  nvsc_q;
  logic signed [2*W+1:0]  ndc_q;
  logic                   frontc_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mu1_q[i] <= k1_q[i] * u[i];
        mu2_q[i] <= k2_q[i] * v[i];
        mk1_q[i] <= k1_q[i] * vvb_q[i];
        mk2_q[i] <= k2_q[i] * vvb_q[i];
      end
      nvsc_q   <= nvv_q[0] + nvv_q[1] + nvv_q[2];
      ndc_q    <= ndb_q;
      frontc_q <= frontb_q;
    end
  end

  // Stage D: dot product sums.
  logic                 vd_q;
  logic signed [MW-1:0] dens_q;
  logic signed [MW-1:0] dent_q;
  logic signed [MW-1:0] dk1_q;
  logic signed [MW-1:0] dk2_q;
  logic signed [MW-1:0] nvsd_q;
  logic signed [MW-1:0] ndd_q;
  logic                 frontd_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dens_q   <= mu1_q[0] + mu1_q[1] + mu1_q[2];
      dent_q   <= mu2_q[0] + mu2_q[1] + mu2_q[2];
      dk1_q    <= mk1_q[0] + mk1_q[1] + mk1_q[2];
      dk2_q    <= mk2_q[0] + mk2_q[1] + mk2_q[2];
      nvsd_q   <= nvsc_q;
      ndd_q    <= ndc_q;
      frontd_q <= frontc_q;
    end
  end

  // Stage E: magnitudes and quotient signs; s and t negate their numerators.
  function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] x);
    return x[MW-1] ? MW'(-x) : MW'(x);
  endfunction

  logic pos_k1;
  logic pos_k2;
  logic miss;

  assign pos_k1 = !dk1_q[MW-1] && (dk1_q != '0);
  assign pos_k2 = !dk2_q[MW-1] && (dk2_q != '0);
  assign miss   = !frontd_q || (dens_q == '0) || (dent_q == '0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o[rpi_pkg::DIV_S] <= mag(dk1_q);
      num_o[rpi_pkg::DIV_T] <= mag(dk2_q);
      num_o[rpi_pkg::DIV_D] <= mag(nvsd_q);
      den_o[rpi_pkg::DIV_S] <= mag(dens_q);
      den_o[rpi_pkg::DIV_T] <= mag(dent_q);
      den_o[rpi_pkg::DIV_D] <= mag(ndd_q);
      neg_o[rpi_pkg::DIV_S] <= pos_k1 ^ dens_q[MW-1];
      neg_o[rpi_pkg::DIV_T] <= pos_k2 ^ dent_q[MW-1];
      neg_o[rpi_pkg::DIV_D] <= nvsd_q[MW-1] ^ ndd_q[MW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      vd_q        <= 1'b0;
      ctl_o.valid <= 1'b0;
      ctl_o.miss  <= 1'b0;
    end else if (en_i) begin
      va_q        <= valid_i;
      vb_q        <= va_q;
      vc_q        <= vb_q;
      vd_q        <= vc_q;
      ctl_o.valid <= vd_q;
      ctl_o.miss  <= miss;
    end
  end

endmodule
`default_nettype wire

@@ src/rpi_divider.sv @@
// Pipelined restoring divider: trunc(num * 2^F / den) with saturated magnitude and sign.
`default_nettype none
module rpi_divider #(
  parameter int MW = 54,
  parameter int F  = 10
) (
  input  wire                        clk_i,
  input  wire                        en_i,
  input  wire  [MW-1:0]              num_i,
  input  wire  [MW-1:0]              den_i,
  input  wire                        neg_i,
  output logic signed [rpi_pkg::QUOT_W-1:0] quo_o
);

  localparam int QB = rpi_pkg::QB;
  localparam int NW = MW + F;

  logic [NW-1:0]    dvd;
  logic [NW-QB-1:0] hi;

  assign dvd = {num_i, {F{1'b0}}};
  assign hi  = dvd[NW-1:QB];

  logic [MW-1:0] r_q   [QB+1];
  logic [QB-1:0] lo_q  [QB+1];
  logic [QB-1:0] q_q   [QB+1];
  logic [MW-1:0] den_q [QB+1];
  logic          ovf_q [QB+1];
  logic          neg_q [QB+1];

  logic [MW:0]   trial [QB+1];
  logic          ge    [QB+1];

  // Stage 0 decides saturation: the quotient reaches 2^31 exactly when the
  // dividend's upper part is not below the divisor.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= MW'(hi);
      lo_q[0]  <= dvd[QB-1:0];
      q_q[0]   <= '0;
      den_q[0] <= den_i;
      ovf_q[0] <= (MW'(hi) >= den_i);
      neg_q[0] <= neg_i;
    end
  end

  always_comb begin
    trial[0] = '0;
    ge[0]    = 1'b0;
    for (int k = 1; k <= QB; k++) begin
      trial[k] = {r_q[k-1], lo_q[k-1][QB-1]};
      ge[k]    = (trial[k] >= {1'b0, den_q[k-1]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 1; k <= QB; k++) begin
        r_q[k]   <= ge[k] ? MW'(trial[k] - {1'b0, den_q[k-1]}) : MW'(trial[k]);
        lo_q[k]  <= {lo_q[k-1][QB-2:0], 1'b0};
        q_q[k]   <= {q_q[k-1][QB-2:0], ge[k]};
        den_q[k] <= den_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  logic [QB-1:0] fin;

  assign fin = ovf_q[QB] ? rpi_pkg::SAT_MAG : q_q[QB];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_o <= neg_q[QB] ? -$signed({1'b0, fin}) : $signed({1'b0, fin});
    end
  end

endmodule
`default_nettype wire

@@ src/ray_parallelogram_intersect.sv @@
// Top level: configuration registers, geometry pipeline, three dividers and the edge test.
// An accepted request passes five geometry stages, 33 divider stages (saturation check,
// 31 quotient bits, sign) and the output register on its way to the result.
// Throughput is one request per cycle; all stages advance together when the output
// register is empty or its result is taken.
// rst_ni clears the valid bits and loads the registers with zero vectors and tolerance 1.
`default_nettype none
module ray_parallelogram_intersect #(
  parameter int COORD_WIDTH = 20,
  parameter int FRAC_BITS   = 10
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [rpi_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [3*COORD_WIDTH-1:0]       cfg_data_i,
  rpi_ray_if.sink                        ray_i,
  rpi_res_if.source                      res_o
);

  localparam int W  = COORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int MW = rpi_pkg::mag_w(W, F);
  localparam int DL = rpi_pkg::DIV_LAT;

  logic [3*W-1:0]            corner_q;
  logic [3*W-1:0]            normal_q;
  logic [3*W-1:0]            edge_u_q;
  logic [3*W-1:0]            edge_v_q;
  logic [rpi_pkg::TOL_W-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= '0;
      normal_q <= '0;
      edge_u_q <= '0;
      edge_v_q <= '0;
      tol_q    <= rpi_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rpi_pkg::CFG_CORNER: corner_q <= cfg_data_i;
        rpi_pkg::CFG_NORMAL: normal_q <= cfg_data_i;
        rpi_pkg::CFG_EDGE_U: edge_u_q <= cfg_data_i;
        rpi_pkg::CFG_EDGE_V: edge_v_q <= cfg_data_i;
        rpi_pkg::CFG_TOL:    tol_q    <= cfg_data_i[rpi_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  logic                   out_vld_q;
  logic                   hit_q;
  logic signed [31:0]     dist_q;
  logic                   en;

  // The whole pipeline moves as one; it stalls only while a result waits.
  assign en          = !out_vld_q || res_o.ready;
  assign ray_i.ready = en;

  logic [2:0][W-1:0] org;
  logic [2:0][W-1:0] dir;

  assign org = {ray_i.origin_z, ray_i.origin_y, ray_i.origin_x};
  assign dir = {ray_i.dir_z, ray_i.dir_y, ray_i.dir_x};

  rpi_pkg::rpi_ctl_t geo_ctl;
  logic [2:0][MW-1:0] num;
  logic [2:0][MW-1:0] den;
  logic [2:0]         neg;

  rpi_geom #(.W(W), .F(F), .MW(MW)) u_geom (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (ray_i.valid),
    .org_i    (org),
    .dir_i    (dir),
    .corner_i (corner_q),
    .normal_i (normal_q),
    .edge_u_i (edge_u_q),
    .edge_v_i (edge_v_q),
    .tol_i    (tol_q),
    .ctl_o    (geo_ctl),
    .num_o    (num),
    .den_o    (den),
    .neg_o    (neg)
  );

  logic signed [rpi_pkg::QUOT_W-1:0] quo [3];

  for (genvar g = 0; g < 3; g++) begin : g_div
    rpi_divider #(.MW(MW), .F(F)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num[g]),
      .den_i (den[g]),
      .neg_i (neg[g]),
      .quo_o (quo[g])
    );
  end

  rpi_pkg::rpi_ctl_t ctl_q [DL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DL; k++) begin
        ctl_q[k] <= '0;
      end
    end else if (en) begin
      ctl_q[0] <= geo_ctl;
      for (int k = 1; k < DL; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  // Edge test: -tol < s < 1 + tol, the same for t.
  logic signed [33:0] s_x;
  logic signed [33:0] t_x;
  logic signed [33:0] tol_x;
  logic signed [33:0] hi_x;
  logic               in_s;
  logic               in_t;
  logic               hit;

  always_comb begin
    s_x   = quo[rpi_pkg::DIV_S];
    t_x   = quo[rpi_pkg::DIV_T];
    tol_x = $signed(34'(tol_q));
    hi_x  = $signed(34'(1) << F) + tol_x;
    in_s  = (s_x > -tol_x) && (s_x < hi_x);
    in_t  = (t_x > -tol_x) && (t_x < hi_x);
    hit   = !ctl_q[DL-1].miss && in_s && in_t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= ctl_q[DL-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= hit;
      dist_q <= hit ? quo[rpi_pkg::DIV_D] : '0;
    end
  end

  assign res_o.valid    = out_vld_q;
  assign res_o.hit      = hit_q;
  assign res_o.distance = dist_q;

`ifndef SYNTH
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !hit_q |-> dist_q == '0)
    else $error("distance not zero on a miss");

  a_sat_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && hit_q |-> dist_q != 32'sh8000_0000)
    else $error("distance below the saturation limit");

  a_pipe_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q[DL-1].valid && !en |=> ctl_q[DL-1].valid)
    else $error("pipeline lost an item during a stall");
`endif

endmodule
`default_nettype wire
